[rtl/lbcd_pkg.sv]
// Package with shared types and constants of the LRU block cache directory.
package lbcd_pkg;
  localparam int CAPACITY = 32;
  localparam int KEY_BITS = 16;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_SYNC  = 2'd2;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_USED  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_t;
endpackage

[rtl/lbcd_ram.sv]
// Generic simple dual-port synchronous RAM with registered read data.
module lbcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/lru_block_cache_directory.sv]
// Top level of the LRU block cache directory.
//
//  channel | ports                                   | handshake
//  input   | in_req_type, in_block_key               | start high while busy low
//  result  | out_hit .. out_last                     | out_valid, one cycle each
//
// An item is processed by a sequencer around per-slot memories. Each memory
// read is issued in a read state and its data is checked in the matching
// check state. A hit probes from the home slot; a miss probes, then searches
// for a free slot, first evicting the head entry when the table is full; a
// sync walks the listed entries; an empty sync or an undefined request goes
// straight to its result. The last result of an item appears in the same
// cycle that busy falls; earlier sync results appear while busy is high.
// After reset a clearing pass sweeps every slot of the status and dirty
// memories, during which busy stays high.
// Results cannot be stalled: each appears with out_valid for exactly one cycle.
module lru_block_cache_directory
  import lbcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_block_key,
  output logic        out_valid,
  output logic        out_hit,
  output logic [4:0]  out_slot_index,
  output logic        out_fill_needed,
  output logic        out_writeback_valid,
  output logic [15:0] out_writeback_key,
  output logic        out_last
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_PRB_RD, S_PRB_CHK, S_HIT_RD, S_HIT_A, S_HIT_B,
    S_MISS_V, S_MISS_VCHK, S_FREE_RD, S_FREE_CHK, S_INS, S_OUT,
    S_SYNC_RD, S_SYNC_CHK
  } state_t;

  state_t state_r;
  logic [AW-1:0] pos_r, slot_r, head_r, tail_r, nxt_r, prv_r;
  logic [CW-1:0] count_r, cnt_r;
  logic [KEY_BITS-1:0] key_r;
  logic [1:0] req_r;
  logic hit_r, wbv_r, any_r;
  logic [15:0] wbk_r;

  // Memory ports: status, dirty, key, next, prev.
  logic st_we, dt_we, ky_we, nx_we, pv_we;
  logic [AW-1:0] st_wa, dt_wa, ky_wa, nx_wa, pv_wa, ra;
  logic [1:0] st_wd, st_rd;
  logic dt_wd, dt_rd;
  logic [KEY_BITS-1:0] ky_rd;
  logic [AW-1:0] nx_wd, nx_rd, pv_wd, pv_rd;

  lbcd_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_st (.clk, .we(st_we), .waddr(st_wa),
    .wdata(st_wd), .raddr(ra), .rdata(st_rd));
  lbcd_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_dt (.clk, .we(dt_we), .waddr(dt_wa),
    .wdata(dt_wd), .raddr(ra), .rdata(dt_rd));
  lbcd_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_ky (.clk, .we(ky_we),
    .waddr(ky_wa), .wdata(key_r), .raddr(ra), .rdata(ky_rd));
  lbcd_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_nx (.clk, .we(nx_we), .waddr(nx_wa),
    .wdata(nx_wd), .raddr(ra), .rdata(nx_rd));
  lbcd_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_pv (.clk, .we(pv_we), .waddr(pv_wa),
    .wdata(pv_wd), .raddr(ra), .rdata(pv_rd));

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    inc = (32'(p) == CAPACITY - 1) ? '0 : AW'(32'(p) + 1);
  endfunction

  logic [AW-1:0] home;
  assign home = AW'(32'(in_block_key[KEY_BITS-1:0]) % CAPACITY);
  assign busy = (state_r != S_IDLE);

  // Combinational memory control; read address follows pos_r.
  always_comb begin
    st_we = 1'b0; dt_we = 1'b0; ky_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
    st_wa = pos_r; dt_wa = pos_r; ky_wa = pos_r; nx_wa = pos_r; pv_wa = pos_r;
    st_wd = ST_EMPTY; dt_wd = 1'b0; nx_wd = '0; pv_wd = '0;
    ra = pos_r;
    case (state_r)
      S_CLR: begin
        st_we = 1'b1; dt_we = 1'b1;
      end
      S_HIT_A: begin
        // Unlink once the links of the slot have been captured: fix the
        // predecessor's next (or the head) and the successor's prev.
        if (any_r) begin
          if (slot_r != tail_r) begin
            nx_we = (slot_r != head_r); nx_wa = prv_r; nx_wd = nxt_r;
            pv_we = 1'b1; pv_wa = nxt_r; pv_wd = prv_r;
          end
          if (req_r == REQ_WRITE) begin
            dt_we = 1'b1; dt_wa = slot_r; dt_wd = 1'b1;
          end
        end
      end
      S_HIT_B: begin
        if (slot_r != tail_r) begin
          nx_we = 1'b1; nx_wa = tail_r; nx_wd = slot_r;
          pv_we = 1'b1; pv_wa = slot_r; pv_wd = tail_r;
        end
      end
      S_MISS_VCHK: begin
        st_we = 1'b1; st_wa = head_r; st_wd = ST_TOMB;
        dt_we = 1'b1; dt_wa = head_r; dt_wd = 1'b0;
      end
      S_INS: begin
        st_we = 1'b1; st_wa = slot_r; st_wd = ST_USED;
        dt_we = 1'b1; dt_wa = slot_r; dt_wd = (req_r == REQ_WRITE);
        ky_we = 1'b1; ky_wa = slot_r;
        if (count_r != '0) begin
          nx_we = 1'b1; nx_wa = tail_r; nx_wd = slot_r;
          pv_we = 1'b1; pv_wa = slot_r; pv_wd = tail_r;
        end
      end
      S_SYNC_CHK: begin
        dt_we = dt_rd; dt_wa = pos_r; dt_wd = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      pos_r <= '0; head_r <= '0; tail_r <= '0; count_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_CLR: begin
          pos_r <= inc(pos_r);
          if (32'(pos_r) == CAPACITY - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_r <= in_req_type;
            key_r <= in_block_key[KEY_BITS-1:0];
            cnt_r <= '0; hit_r <= 1'b0; wbv_r <= 1'b0; wbk_r <= '0; any_r <= 1'b0;
            slot_r <= '0;
            case (in_req_type)
              REQ_READ, REQ_WRITE: begin pos_r <= home; state_r <= S_PRB_RD; end
              REQ_SYNC: begin
                pos_r <= head_r;
                state_r <= (count_r == '0) ? S_OUT : S_SYNC_RD;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_PRB_RD: state_r <= S_PRB_CHK;
        S_PRB_CHK: begin
          if (st_rd == ST_USED && ky_rd == key_r) begin
            slot_r <= pos_r; hit_r <= 1'b1; state_r <= S_HIT_RD;
          end else if (st_rd == ST_EMPTY || 32'(cnt_r) == CAPACITY - 1) begin
            cnt_r <= '0;
            if (32'(count_r) >= CAPACITY) begin
              pos_r <= head_r; state_r <= S_MISS_V;
            end else begin
              pos_r <= AW'(32'(key_r) % CAPACITY); state_r <= S_FREE_RD;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1; pos_r <= inc(pos_r); state_r <= S_PRB_RD;
          end
        end
        S_HIT_RD: state_r <= S_HIT_A;
        S_HIT_A: begin
          nxt_r <= nx_rd; prv_r <= pv_rd;
          state_r <= S_HIT_A;
          // first visit here captures links; handled via any_r
          if (!any_r) begin
            any_r <= 1'b1;
          end
          if (any_r) begin
            if (slot_r == head_r && slot_r != tail_r) head_r <= nxt_r;
            state_r <= S_HIT_B;
          end
        end
        S_HIT_B: begin
          tail_r <= slot_r; state_r <= S_OUT;
        end
        S_MISS_V: state_r <= S_MISS_VCHK;
        S_MISS_VCHK: begin
          if (dt_rd) begin
            wbv_r <= 1'b1; wbk_r <= 16'(ky_rd);
          end
          if (count_r > 1) head_r <= nx_rd;
          count_r <= count_r - 1'b1;
          pos_r <= AW'(32'(key_r) % CAPACITY);
          state_r <= S_FREE_RD;
        end
        S_FREE_RD: state_r <= S_FREE_CHK;
        S_FREE_CHK: begin
          if (st_rd != ST_USED || 32'(cnt_r) == CAPACITY - 1) begin
            slot_r <= (st_rd != ST_USED) ? pos_r : AW'(32'(key_r) % CAPACITY);
            state_r <= S_INS;
          end else begin
            cnt_r <= cnt_r + 1'b1; pos_r <= inc(pos_r); state_r <= S_FREE_RD;
          end
        end
        S_INS: begin
          if (count_r == '0) head_r <= slot_r;
          tail_r <= slot_r;
          count_r <= count_r + 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_hit <= hit_r;
          out_slot_index <= 5'(slot_r);
          out_fill_needed <= (req_r == REQ_READ || req_r == REQ_WRITE) && !hit_r;
          out_writeback_valid <= wbv_r;
          out_writeback_key <= wbk_r;
          out_last <= 1'b1;
          state_r <= S_IDLE;
        end
        S_SYNC_RD: state_r <= S_SYNC_CHK;
        S_SYNC_CHK: begin
          // The newest dirty entry is held in slot_r and wbk_r so that the
          // final one can leave through S_OUT with the last marker. An empty
          // hold there gives the all-zero result of a sync with nothing dirty.
          if (dt_rd) begin
            if (wbv_r) begin
              out_valid <= 1'b1; out_hit <= 1'b0; out_fill_needed <= 1'b0;
              out_slot_index <= 5'(slot_r); out_writeback_valid <= 1'b1;
              out_writeback_key <= wbk_r;
              out_last <= 1'b0;
            end
            slot_r <= pos_r; wbv_r <= 1'b1; wbk_r <= 16'(ky_rd);
          end
          pos_r <= nx_rd;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == count_r - 1'b1) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_SYNC_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/lbcd_checker.sv]
// Port-level assertions for the LRU block cache directory, bound to the top.
module lbcd_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_hit,
  input logic out_fill_needed,
  input logic out_writeback_valid,
  input logic out_last
);
  a_hit_nofill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_fill_needed)) else $error("hit with fill");
  a_hit_nowb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_writeback_valid) else $error("hit with writeback");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept without busy");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid) else $error("result after last");
endmodule

bind lru_block_cache_directory lbcd_checker u_lbcd_checker (.*);
